/* sv/lcrl_pkg.sv */
package lcrl_pkg;

   typedef logic signed [31:0] value_type;
   typedef logic [2:0] state_type;

   localparam int RUN_W = 9;
   localparam int RUN_MAX = 511;
   localparam value_type VALUE_MAX = 32'sh7FFF_FFFF;

   localparam state_type S_LOAD   = 3'd0;
   localparam state_type S_KEY_RD = 3'd1;
   localparam state_type S_KEY    = 3'd2;
   localparam state_type S_CMP    = 3'd3;
   localparam state_type S_WALK0  = 3'd4;
   localparam state_type S_WALK1  = 3'd5;
   localparam state_type S_WALK2  = 3'd6;

endpackage

/* sv/longest_consecutive_run_length_unit.sv */
// Longest run of consecutive integers in a set of signed 32-bit words.
// Input: a word is taken at a rising edge with start high and busy low.
// Each word carries req_value and req_last; req_last closes the set.
// Up to MAX_ITEMS words are written to an internal memory, one per cycle,
// while busy stays low. Further words are dropped and the overflow flag is set.
// After the last word, busy goes high while the stored words are sorted
// in place by insertion sort and then walked once in order; the memory's
// single read port paces both passes. The result word appears on
// rsp_run_length and rsp_overflowed for one cycle with rsp_valid high;
// the receiver cannot stall it.
// The block then clears its count and flag and drops busy for the next set.
// Reset clears the control state; the memory contents are not cleared,
// since every entry is written before it is read.
module longest_consecutive_run_length_unit #(
   parameter int MAX_ITEMS = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  lcrl_pkg::value_type      req_value,
   input  logic                     req_last,
   output logic                     rsp_valid,
   output logic [lcrl_pkg::RUN_W-1:0] rsp_run_length,
   output logic                     rsp_overflowed
);
   import lcrl_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int WIDE_W = CNT_W + RUN_W;

   value_type mem [MAX_ITEMS];
   value_type rdata_ff;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, best_ff, best_in, cnt_next;
   value_type key_ff, key_in, prev_ff, prev_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RUN_W-1:0] len_ff, len_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   logic rd_en, wr_en;
   logic [CNT_W-1:0] rd_idx, wr_idx;
   value_type wr_data;
   logic accept;
   logic full;
   logic [WIDE_W-1:0] best_wide;

   assign busy = (state_ff != S_LOAD);
   assign accept = start && !busy;
   assign full = (count_ff == CNT_W'(MAX_ITEMS));
   assign best_wide = {{RUN_W{1'b0}}, best_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_idx[IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      best_in = best_ff;
      key_in = key_ff;
      prev_in = prev_ff;
      rsp_valid_in = 1'b0;
      len_in = len_ff;
      rsp_ovf_in = rsp_ovf_ff;
      rd_en = 1'b0;
      rd_idx = i_ff;
      wr_en = 1'b0;
      wr_idx = count_ff;
      wr_data = req_value;
      cnt_next = cnt_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_last) begin
                  i_in = CNT_W'(1);
                  if (count_in > CNT_W'(1)) begin
                     state_in = S_KEY_RD;
                  end else begin
                     state_in = S_WALK0;
                  end
               end
            end
         end
         S_KEY_RD: begin
            rd_en = 1'b1;
            rd_idx = i_ff;
            state_in = S_KEY;
         end
         S_KEY: begin
            key_in = rdata_ff;
            j_in = i_ff;
            rd_en = 1'b1;
            rd_idx = i_ff - 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            wr_en = 1'b1;
            wr_idx = j_ff;
            if (j_ff != '0 && rdata_ff > key_ff) begin
               wr_data = rdata_ff;
               j_in = j_ff - 1'b1;
               rd_en = 1'b1;
               rd_idx = j_ff - CNT_W'(2);
            end else begin
               wr_data = key_ff;
               i_in = i_ff + 1'b1;
               if (i_in < count_ff) begin
                  state_in = S_KEY_RD;
               end else begin
                  state_in = S_WALK0;
               end
            end
         end
         S_WALK0: begin
            rd_en = 1'b1;
            rd_idx = '0;
            state_in = S_WALK1;
         end
         S_WALK1: begin
            prev_in = rdata_ff;
            cnt_in = CNT_W'(1);
            best_in = CNT_W'(1);
            k_in = CNT_W'(1);
            rd_en = 1'b1;
            rd_idx = CNT_W'(1);
            state_in = S_WALK2;
         end
         S_WALK2: begin
            if (k_ff == count_ff) begin
               rsp_valid_in = 1'b1;
               if (best_wide > WIDE_W'(RUN_MAX)) begin
                  len_in = RUN_W'(RUN_MAX);
               end else begin
                  len_in = best_wide[RUN_W-1:0];
               end
               rsp_ovf_in = ovf_ff;
               count_in = '0;
               ovf_in = 1'b0;
               state_in = S_LOAD;
            end else begin
               if (prev_ff != VALUE_MAX && rdata_ff == value_type'(prev_ff + 32'sd1)) begin
                  cnt_next = cnt_ff + 1'b1;
               end else if (rdata_ff != prev_ff) begin
                  cnt_next = CNT_W'(1);
               end
               cnt_in = cnt_next;
               if (cnt_next > best_ff) begin
                  best_in = cnt_next;
               end
               prev_in = rdata_ff;
               k_in = k_ff + 1'b1;
               rd_en = 1'b1;
               rd_idx = k_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      cnt_ff <= cnt_in;
      best_ff <= best_in;
      key_ff <= key_in;
      prev_ff <= prev_in;
      len_ff <= len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_run_length = len_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_nonzero_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_length != '0)
      else $error("result with zero run length");

   a_last_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> busy)
      else $error("last word did not start the search");

   a_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff == '0 && !ovf_ff && !busy))
      else $error("set state not cleared after result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("stored count beyond capacity");

endmodule
